@@ rtl/ffd_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fractional feedback delay package
// Sizes, register codes, the multiply-accumulate control word and the
// saturation helper shared by the delay line modules.
// ----------------------------------------------------------------------------
package ffd_pkg;

	localparam int RING_DEPTH  = 32768;
	localparam int SAMPLE_BITS = 16;

	localparam int ADDR_W    = $clog2(RING_DEPTH);
	localparam int FILL_W    = ADDR_W + 1;
	localparam int DW_W      = 15;
	localparam int FRAC_W    = 16;
	localparam int GAIN_W    = 16;
	localparam int CFG_W     = 16;
	localparam int CFG_IDX_W = 3;

	localparam int OPA_W = SAMPLE_BITS + 1;
	localparam int OPB_W = FRAC_W + 1;
	localparam int ACC_W = OPA_W + OPB_W;

	localparam int RED_W   = ((DW_W > ADDR_W) ? DW_W : ADDR_W) + 1;
	localparam int RED_K   = (DW_W > ADDR_W) ? (DW_W - ADDR_W) : 0;
	localparam int RED_K_W = (RED_K > 0) ? $clog2(RED_K + 1) : 1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DELAY_WHOLE,
		REG_DELAY_FRACTION,
		REG_FEEDBACK_GAIN,
		REG_TAP_GAIN,
		REG_MIX_GAIN
	} cfg_reg_t;

	typedef struct packed {
		logic en;
		logic clr;
	} mac_ctl_t;

	function automatic logic signed [SAMPLE_BITS-1:0] sat_sample(
		input logic signed [ACC_W-1:0] v
	);
		logic signed [ACC_W-1:0] hi;
		logic signed [ACC_W-1:0] lo;
		hi = ACC_W'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
		lo = -hi - ACC_W'(1);
		if (v > hi) begin
			return SAMPLE_BITS'(hi);
		end else if (v < lo) begin
			return SAMPLE_BITS'(lo);
		end
		return SAMPLE_BITS'(v);
	endfunction

endpackage

@@ rtl/ffd_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fractional feedback delay stream interfaces
// Valid/ready channels for the input and output sample words.
// ----------------------------------------------------------------------------
interface ffd_in_if import ffd_pkg::*; ();
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] sample_in;

	modport source (output valid, output sample_in, input ready);
	modport sink (input valid, input sample_in, output ready);
endinterface

interface ffd_out_if import ffd_pkg::*; ();
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] sample_out;

	modport source (output valid, output sample_out, input ready);
	modport sink (input valid, input sample_out, output ready);
endinterface

@@ rtl/ffd_ring.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fractional feedback delay ring memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module ffd_ring import ffd_pkg::*; (
	input  logic                   clk,
	input  logic                   we,
	input  logic [ADDR_W-1:0]      waddr,
	input  logic [SAMPLE_BITS-1:0] wdata,
	input  logic [ADDR_W-1:0]      raddr,
	output logic [SAMPLE_BITS-1:0] rdata
);

	logic [SAMPLE_BITS-1:0] mem_q [RING_DEPTH];
	logic [SAMPLE_BITS-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

@@ rtl/ffd_mac.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fractional feedback delay multiply-accumulate unit
// Shared signed multiplier feeding a clearable accumulator register.
// ----------------------------------------------------------------------------
module ffd_mac import ffd_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  mac_ctl_t                ctl,
	input  logic signed [OPA_W-1:0] a,
	input  logic signed [OPB_W-1:0] b,
	output logic signed [ACC_W-1:0] acc
);

	logic signed [ACC_W-1:0] acc_q;
	logic signed [ACC_W-1:0] prod;

	assign prod = a * b;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (ctl.en) begin
			acc_q <= (ctl.clr ? ACC_W'(0) : acc_q) + prod;
		end
	end

	assign acc = acc_q;

endmodule

@@ rtl/fractional_feedback_delay_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fractional feedback delay top level
// Interpolating delay line with feedback, built around one shared
// multiply-accumulate unit and a ring memory with one read port.
// ----------------------------------------------------------------------------
// Usage:
// Each input word on din is one signed sample. The block reads the ring at the
// whole delay and one sample further back, blends the two reads by the
// fractional delay, stores the input plus the fed back estimate and returns
// one output word on dout per input word.
// Configuration registers are written through cfg_we, cfg_idx and cfg_wdata
// while the block is idle; writes to indexes above four are ignored.
// An input word is taken only while the sequencer is idle, so a new word is
// not accepted before the last one is through. The sequencer steps through
// the delay reduction modulo the ring size, two reads through the single
// memory read port and four passes through the shared multiplier, and then
// loads the output word.
// After reset the ring reads as all zeros through a fill count, so no clear
// pass is needed; the write position starts at the last entry.
// A finished word waits in the output register while the next input word is
// taken; the sequencer only stalls if a second result is ready before the
// receiver has taken the first.
// ----------------------------------------------------------------------------
module fractional_feedback_delay_top import ffd_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_idx,
	input  logic [CFG_W-1:0]     cfg_wdata,
	ffd_in_if.sink               din,
	ffd_out_if.source            dout
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_REDUCE,
		S_ADDR,
		S_RDOLD,
		S_DIFF,
		S_EST,
		S_FB,
		S_ACC,
		S_MIX,
		S_TAP,
		S_OUT
	} state_t;

	localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(RING_DEPTH - 1);

	state_t                        state_q;
	logic [DW_W-1:0]               delay_whole_q;
	logic [FRAC_W-1:0]             delay_fraction_q;
	logic signed [GAIN_W-1:0]      feedback_gain_q;
	logic signed [GAIN_W-1:0]      tap_gain_q;
	logic signed [GAIN_W-1:0]      mix_gain_q;

	logic signed [SAMPLE_BITS-1:0] x_q;
	logic [RED_W-1:0]              wd_q;
	logic [RED_K_W-1:0]            k_q;
	logic [ADDR_W-1:0]             rd_old_q;
	logic                          vnew_q;
	logic                          vold_q;
	logic signed [SAMPLE_BITS-1:0] newer_q;
	logic signed [SAMPLE_BITS-1:0] est_q;
	logic signed [SAMPLE_BITS-1:0] accv_q;
	logic [ADDR_W-1:0]             wp_q;
	logic [FILL_W-1:0]             fill_q;
	logic signed [SAMPLE_BITS-1:0] out_q;
	logic                          out_valid_q;

	logic [RED_W-1:0]              red_sub;
	logic [ADDR_W-1:0]             d_red;
	logic [ADDR_W-1:0]             rd_new;
	logic [ADDR_W-1:0]             rd_new_prev;
	logic [ADDR_W-1:0]             rd_new_succ;
	logic                          fill_full;
	logic                          valid_new;
	logic                          valid_old;
	logic [ADDR_W-1:0]             ring_raddr;
	logic [SAMPLE_BITS-1:0]        ring_rdata;
	logic signed [SAMPLE_BITS-1:0] ring_sample;
	logic signed [SAMPLE_BITS-1:0] older;
	logic signed [ACC_W-1:0]       mac_acc;
	logic signed [ACC_W-1:0]       est_full;
	logic signed [ACC_W-1:0]       fb_sum;
	logic signed [SAMPLE_BITS-1:0] accv;
	logic signed [SAMPLE_BITS-1:0] y;
	logic signed [OPA_W-1:0]       mac_a;
	logic signed [OPB_W-1:0]       mac_b;
	mac_ctl_t                      mac_ctl;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delay_whole_q    <= '0;
			delay_fraction_q <= '0;
			feedback_gain_q  <= '0;
			tap_gain_q       <= '0;
			mix_gain_q       <= '0;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_idx))
				REG_DELAY_WHOLE:    delay_whole_q    <= cfg_wdata[DW_W-1:0];
				REG_DELAY_FRACTION: delay_fraction_q <= cfg_wdata[FRAC_W-1:0];
				REG_FEEDBACK_GAIN:  feedback_gain_q  <= $signed(cfg_wdata[GAIN_W-1:0]);
				REG_TAP_GAIN:       tap_gain_q       <= $signed(cfg_wdata[GAIN_W-1:0]);
				REG_MIX_GAIN:       mix_gain_q       <= $signed(cfg_wdata[GAIN_W-1:0]);
				default: begin
				end
			endcase
		end
	end

	assign red_sub = RED_W'(RING_DEPTH) << k_q;
	assign d_red   = wd_q[ADDR_W-1:0];

	assign rd_new = (wp_q >= d_red) ? (wp_q - d_red)
		: ADDR_W'({1'b0, wp_q} + FILL_W'(RING_DEPTH) - {1'b0, d_red});
	assign rd_new_prev = (rd_new == '0) ? LAST_ADDR : (rd_new - 1'b1);
	assign rd_new_succ = (rd_new == LAST_ADDR) ? '0 : (rd_new + 1'b1);

	// An entry was written once the write order that reaches it is below the fill count.
	assign fill_full = (fill_q == FILL_W'(RING_DEPTH));
	assign valid_new = fill_full || ({1'b0, rd_new_succ} < fill_q);
	assign valid_old = fill_full || ({1'b0, rd_new} < fill_q);

	assign ring_raddr  = (state_q == S_ADDR) ? rd_new : rd_old_q;
	assign ring_sample = $signed(ring_rdata);
	assign older       = vold_q ? ring_sample : '0;

	assign est_full = ACC_W'(newer_q) + (mac_acc >>> FRAC_W);
	assign fb_sum   = ACC_W'(x_q) + (mac_acc >>> (GAIN_W - 1));
	assign accv     = sat_sample(fb_sum);
	assign y        = sat_sample(mac_acc >>> (GAIN_W - 1));

	always_comb begin
		mac_ctl = '0;
		mac_a   = '0;
		mac_b   = '0;
		case (state_q)
			S_DIFF: begin
				mac_ctl = '{en: 1'b1, clr: 1'b1};
				mac_a   = OPA_W'(older) - OPA_W'(newer_q);
				mac_b   = $signed({1'b0, delay_fraction_q});
			end
			S_FB: begin
				mac_ctl = '{en: 1'b1, clr: 1'b1};
				mac_a   = OPA_W'(est_q);
				mac_b   = OPB_W'(feedback_gain_q);
			end
			S_MIX: begin
				mac_ctl = '{en: 1'b1, clr: 1'b1};
				mac_a   = OPA_W'(accv_q);
				mac_b   = OPB_W'(mix_gain_q);
			end
			S_TAP: begin
				mac_ctl = '{en: 1'b1, clr: 1'b0};
				mac_a   = OPA_W'(est_q);
				mac_b   = OPB_W'(tap_gain_q);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			x_q         <= '0;
			wd_q        <= '0;
			k_q         <= '0;
			rd_old_q    <= '0;
			vnew_q      <= 1'b0;
			vold_q      <= 1'b0;
			newer_q     <= '0;
			est_q       <= '0;
			accv_q      <= '0;
			wp_q        <= LAST_ADDR;
			fill_q      <= '0;
			out_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (dout.ready && state_q != S_OUT) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (din.valid) begin
						x_q     <= din.sample_in;
						wd_q    <= RED_W'(delay_whole_q);
						k_q     <= RED_K_W'(RED_K);
						state_q <= S_REDUCE;
					end
				end
				S_REDUCE: begin
					if (wd_q >= red_sub) begin
						wd_q <= wd_q - red_sub;
					end
					if (k_q == '0) begin
						state_q <= S_ADDR;
					end else begin
						k_q <= k_q - 1'b1;
					end
				end
				S_ADDR: begin
					rd_old_q <= rd_new_prev;
					vnew_q   <= valid_new;
					vold_q   <= valid_old;
					state_q  <= S_RDOLD;
				end
				S_RDOLD: begin
					newer_q <= vnew_q ? ring_sample : '0;
					state_q <= S_DIFF;
				end
				S_DIFF: begin
					state_q <= S_EST;
				end
				S_EST: begin
					est_q   <= est_full[SAMPLE_BITS-1:0];
					state_q <= S_FB;
				end
				S_FB: begin
					state_q <= S_ACC;
				end
				S_ACC: begin
					accv_q <= accv;
					wp_q   <= (wp_q == LAST_ADDR) ? '0 : (wp_q + 1'b1);
					if (!fill_full) begin
						fill_q <= fill_q + 1'b1;
					end
					state_q <= S_MIX;
				end
				S_MIX: begin
					state_q <= S_TAP;
				end
				S_TAP: begin
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (!out_valid_q || dout.ready) begin
						out_q       <= y;
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign din.ready       = (state_q == S_IDLE);
	assign dout.valid      = out_valid_q;
	assign dout.sample_out = out_q;

	ffd_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (mac_ctl),
		.a      (mac_a),
		.b      (mac_b),
		.acc    (mac_acc)
	);

	ffd_ring u_ring (
		.clk   (clk),
		.we    (state_q == S_ACC),
		.waddr (wp_q),
		.wdata (accv),
		.raddr (ring_raddr),
		.rdata (ring_rdata)
	);

	// The fill count saturates at the ring size.
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FILL_W'(RING_DEPTH))
		else $error("fill count beyond ring size");

	// The reduced delay is a valid ring offset once address generation starts.
	a_delay_reduced: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_ADDR |-> wd_q < RED_W'(RING_DEPTH))
		else $error("delay not reduced modulo ring size");

	// The interpolated estimate lies between the two reads and fits a sample.
	a_est_fits: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_FB |-> est_full == ACC_W'(est_q))
		else $error("interpolated estimate truncated");

	// A new output word is only loaded at the end of an item.
	a_out_load: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_OUT))
		else $error("output word loaded outside the output step");

endmodule
